### sv/mtf_pkg.sv
// Shared types, constants and the initial-order function for the move-to-front coder.
// No dependencies; every other file of the coder imports this package.
`timescale 1ns / 1ps

package mtf_pkg;

  // Default alphabet size and the fixed width of the symbol/value fields
  localparam int ALPHABET_SIZE_DEF = 128;
  localparam int VALUE_W           = 7;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_VARIANT   = 1'b1;

  // Characters that open the initial order
  localparam int CHAR_DASH = 45;
  localparam int CHAR_DOT  = 46;
  localparam int CHAR_STAR = 42;
  localparam int CHAR_UC_A = 65;
  localparam int CHAR_UC_Z = 90;
  localparam int CHAR_LC_A = 97;
  localparam int CHAR_LC_Z = 122;
  localparam int PREFIX_LEN = 55;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // item taken: latch input, restore order on block start
    logic match;    // compare every slot, register the hit vector
    logic resolve;  // reduce the hit vector to position, symbol and result
    logic commit;   // update the list and load the output register
  } mtf_cmd_t;

  // k-th code of the fixed prefix: '-', '.', A-Z, a-z, '*'
  function automatic int prefix_code(input int k);
    int c;
    if (k == 0) begin
      c = CHAR_DASH;
    end else if (k == 1) begin
      c = CHAR_DOT;
    end else if (k < 28) begin
      c = CHAR_UC_A + k - 2;
    end else if (k < 54) begin
      c = CHAR_LC_A + k - 28;
    end else begin
      c = CHAR_STAR;
    end
    return c;
  endfunction

  function automatic bit is_prefix(input int c);
    return (c == CHAR_DASH) || (c == CHAR_DOT) || (c == CHAR_STAR) ||
           ((c >= CHAR_UC_A) && (c <= CHAR_UC_Z)) ||
           ((c >= CHAR_LC_A) && (c <= CHAR_LC_Z));
  endfunction

  // Symbol held at list position idx after a restore, for an alphabet of n codes
  function automatic int init_entry(input int n, input int idx);
    int count;
    int c;
    int found;
    count = 0;
    found = 0;
    for (int k = 0; k < PREFIX_LEN; k++) begin
      c = prefix_code(k);
      if (c < n) begin
        if (count == idx) found = c;
        count++;
      end
    end
    for (int j = 0; j < n; j++) begin
      if (!is_prefix(j)) begin
        if (count == idx) found = j;
        count++;
      end
    end
    return found;
  endfunction

endpackage

### sv/mtf_ctrl.sv
// Controller of the move-to-front coder: item sequencing and output valid.
// Depends on mtf_pkg for the command struct.
`timescale 1ns / 1ps

module mtf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output mtf_pkg::mtf_cmd_t cmd_o
);
  import mtf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_MATCH   = 4'b0010,
    S_RESOLVE = 4'b0100,
    S_COMMIT  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   commit;

  // Handshake decode
  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign commit      = (state_q == S_COMMIT) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load = accept;
        if (accept) state_d = S_MATCH;
      end
      S_MATCH: begin
        cmd_o.match = 1'b1;
        state_d     = S_RESOLVE;
      end
      S_RESOLVE: begin
        cmd_o.resolve = 1'b1;
        state_d       = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.commit = commit;
        if (commit) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output register valid: set on commit, cleared when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Checks
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == S_MATCH)
    else $error("accepted item did not start the match step");

  a_valid_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_COMMIT))
    else $error("output valid rose outside commit");

  a_commit_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_COMMIT && out_valid_q && out_stall_i |=> state_q == S_COMMIT)
    else $error("commit overran a waiting result");

  a_commit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_q)
    else $error("commit did not present a result");

endmodule

### sv/mtf_dpath.sv
// Datapath of the move-to-front coder: list slots, config registers, output register.
// Depends on mtf_pkg for constants, the command struct and the initial order.
`timescale 1ns / 1ps

module mtf_dpath #(
  parameter int ALPHABET_SIZE = mtf_pkg::ALPHABET_SIZE_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mtf_pkg::mtf_cmd_t              cmd_i,
  input  logic [mtf_pkg::VALUE_W-1:0]    symbol_in_i,
  input  logic                           block_start_i,
  input  logic                           cfg_valid_i,
  input  logic [mtf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic                           cfg_data_i,
  output logic [mtf_pkg::VALUE_W-1:0]    value_out_o
);
  import mtf_pkg::*;

  localparam int PW = $clog2(ALPHABET_SIZE);
  localparam int CW = (PW > VALUE_W) ? PW : VALUE_W;

  logic              dir_q, var_q;
  logic [VALUE_W-1:0] sym_q;
  logic [PW-1:0]     slot_q [ALPHABET_SIZE];
  logic [PW-1:0]     slot_d [ALPHABET_SIZE];
  logic [ALPHABET_SIZE-1:0] match_q, match_d;
  logic [PW-1:0]     pos_c, pos_q;
  logic [PW-1:0]     sel_c, sel_q;
  logic              hit_q;
  logic [VALUE_W-1:0] res_q;
  logic [VALUE_W-1:0] value_q;
  logic [PW-1:0]     head;
  logic              promote;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;
      var_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DIRECTION: dir_q <= cfg_data_i;
        CFG_VARIANT:   var_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) sym_q <= symbol_in_i;
  end

  // Per-slot hit: content equals symbol (encode) or slot index equals position (decode)
  always_comb begin
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      if (dir_q) begin
        match_d[i] = (CW'(sym_q) == CW'(i));
      end else begin
        match_d[i] = (CW'(slot_q[i]) == CW'(sym_q));
      end
    end
  end

  // Reduce the one-hot hit vector to its position and the symbol there
  always_comb begin
    pos_c = '0;
    sel_c = '0;
    for (int i = 0; i < ALPHABET_SIZE; i++) begin
      if (match_q[i]) begin
        pos_c = pos_c | PW'(i);
        sel_c = sel_c | slot_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.match) match_q <= match_d;
    if (cmd_i.resolve) begin
      pos_q <= pos_c;
      sel_q <= sel_c;
      hit_q <= |match_q;
      // no hit leaves both reductions at zero
      res_q <= dir_q ? VALUE_W'(sel_c) : VALUE_W'(pos_c);
    end
    if (cmd_i.commit) value_q <= res_q;
  end

  // Insert point: MTF-1 keeps the head unless the symbol sits right below it
  assign head    = (var_q && (pos_q != PW'(1))) ? PW'(1) : '0;
  assign promote = hit_q && (pos_q != '0);

  // List slots: restore, shift down by one between head and position, insert
  for (genvar g = 0; g < ALPHABET_SIZE; g++) begin : g_slot
    localparam logic [PW-1:0] INIT = PW'(init_entry(ALPHABET_SIZE, g));

    always_comb begin
      slot_d[g] = slot_q[g];
      if (cmd_i.load && block_start_i) begin
        slot_d[g] = INIT;
      end else if (cmd_i.commit && promote) begin
        if (PW'(g) == head) begin
          slot_d[g] = sel_q;
        end else if ((PW'(g) > head) && (PW'(g) <= pos_q)) begin
          slot_d[g] = slot_q[(g > 0) ? g - 1 : 0];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        slot_q[g] <= INIT;
      end else begin
        slot_q[g] <= slot_d[g];
      end
    end
  end

  assign value_out_o = value_q;

endmodule

### sv/move_to_front_coder_top.sv
// Move-to-front coder over a configurable alphabet (128 symbols by default).
// Every accepted item is latched (restoring the initial order '-', '.', A-Z,
// a-z, '*', rest ascending when block_start_i is set), then all list slots
// compare in parallel, then the hit is reduced to a position and symbol, and
// finally the commit shifts the slot row and loads the output register. The next
// item is taken as soon as that commit is done, even while the result still waits
// behind out_stall_i; the commit step waits only if an earlier result is still
// unread. direction (index 0) selects encode or decode, variant (index 1) selects
// classic or MTF-1; write them only while the coder is idle.
// Depends on mtf_pkg, mtf_ctrl and mtf_dpath.
`timescale 1ns / 1ps

module move_to_front_coder_top #(
  parameter int ALPHABET_SIZE = mtf_pkg::ALPHABET_SIZE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [mtf_pkg::VALUE_W-1:0]   symbol_in_i,
  input  logic                          block_start_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [mtf_pkg::VALUE_W-1:0]   value_out_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mtf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic                          cfg_data_i
);
  import mtf_pkg::*;

  mtf_cmd_t cmd;

  // Registers are always writable
  assign cfg_ready_o = 1'b1;

  mtf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  mtf_dpath #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .symbol_in_i   (symbol_in_i),
    .block_start_i (block_start_i),
    .cfg_valid_i   (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .value_out_o   (value_out_o)
  );

endmodule
